// File: sv/rfo_pkg.sv
// Shared types, constants and the microcode table of the rotor flux observer.
// Used by rfo_alu and rotor_flux_observer_rk4_core; depends on nothing else.
package rfo_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int STEP_SIZE_W   = 31;
   // k1 + 2*k2 + 2*k3 + k4 of 32-bit terms fits in 35 signed bits
   localparam int ACC_W         = 35;
   localparam int CSR_IDX_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_ALPHA = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_BETA  = 3'd5;

   localparam int UOP_COUNT  = 72;
   localparam int UOP_STEP_W = $clog2(UOP_COUNT);

   localparam logic ACC_ALPHA = 1'b0;
   localparam logic ACC_BETA  = 1'b1;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MUL,
      OP_ADD,
      OP_SUB,
      OP_ACC_LD,
      OP_ACC_ADD,
      OP_ACC_ADD2,
      OP_ACC_SAT
   } alu_op_type;

   typedef enum logic [4:0] {
      SRC_ZERO,
      SRC_CHALF,
      SRC_C0667,
      SRC_C06667,
      SRC_C0866,
      SRC_DECAY,
      SRC_MAG,
      SRC_POLE,
      SRC_H,
      SRC_HH,
      SRC_H6,
      SRC_A,
      SRC_B,
      SRC_C,
      SRC_WS,
      SRC_PA,
      SRC_PB,
      SRC_IA,
      SRC_IB,
      SRC_W,
      SRC_MA,
      SRC_MB,
      SRC_XA,
      SRC_XB,
      SRC_KA,
      SRC_KB,
      SRC_T0,
      SRC_T1
   } src_type;

   typedef struct packed {
      alu_op_type op;
      logic       acc_sel;
      src_type    dst;
      src_type    srca;
      src_type    srcb;
   } uop_type;

   typedef struct packed {
      logic       fire;
      alu_op_type op;
      logic       acc_sel;
   } alu_ctl_type;

   function automatic uop_type mk(alu_op_type op, src_type dst, src_type a, src_type b,
                                  logic sel);
      uop_type u;
      u.op      = op;
      u.acc_sel = sel;
      u.dst     = dst;
      u.srca    = a;
      u.srcb    = b;
      return u;
   endfunction

   // One RK4 step: Clarke transform, speed scaling, four derivative passes
   // over (xa, xb), weighted sum and final update of the flux pair.
   function automatic uop_type uop_at(logic [UOP_STEP_W-1:0] step);
      uop_type u;
      unique case (int'(step))
         // stator current pair and electrical speed
         0:  u = mk(OP_MUL, SRC_T0, SRC_CHALF,  SRC_B,    ACC_ALPHA);
         1:  u = mk(OP_SUB, SRC_T1, SRC_A,      SRC_T0,   ACC_ALPHA);
         2:  u = mk(OP_MUL, SRC_T0, SRC_CHALF,  SRC_C,    ACC_ALPHA);
         3:  u = mk(OP_SUB, SRC_T1, SRC_T1,     SRC_T0,   ACC_ALPHA);
         4:  u = mk(OP_MUL, SRC_IA, SRC_C0667,  SRC_T1,   ACC_ALPHA);
         5:  u = mk(OP_MUL, SRC_T0, SRC_C0866,  SRC_B,    ACC_ALPHA);
         6:  u = mk(OP_MUL, SRC_T1, SRC_C0866,  SRC_C,    ACC_ALPHA);
         7:  u = mk(OP_SUB, SRC_T0, SRC_T0,     SRC_T1,   ACC_ALPHA);
         8:  u = mk(OP_MUL, SRC_IB, SRC_C06667, SRC_T0,   ACC_ALPHA);
         9:  u = mk(OP_MUL, SRC_W,  SRC_WS,     SRC_POLE, ACC_ALPHA);
         10: u = mk(OP_MUL, SRC_MA, SRC_MAG,    SRC_IA,   ACC_ALPHA);
         11: u = mk(OP_MUL, SRC_MB, SRC_MAG,    SRC_IB,   ACC_ALPHA);
         12: u = mk(OP_ADD, SRC_XA, SRC_PA,     SRC_ZERO, ACC_ALPHA);
         13: u = mk(OP_ADD, SRC_XB, SRC_PB,     SRC_ZERO, ACC_ALPHA);
         // k1
         14: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XB,   ACC_ALPHA);
         15: u = mk(OP_SUB, SRC_T1, SRC_MA,     SRC_T0,   ACC_ALPHA);
         16: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XA,   ACC_ALPHA);
         17: u = mk(OP_SUB, SRC_KA, SRC_T1,     SRC_T0,   ACC_ALPHA);
         18: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XA,   ACC_ALPHA);
         19: u = mk(OP_ADD, SRC_T1, SRC_MB,     SRC_T0,   ACC_ALPHA);
         20: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XB,   ACC_ALPHA);
         21: u = mk(OP_SUB, SRC_KB, SRC_T1,     SRC_T0,   ACC_ALPHA);
         22: u = mk(OP_ACC_LD, SRC_ZERO, SRC_KA, SRC_ZERO, ACC_ALPHA);
         23: u = mk(OP_ACC_LD, SRC_ZERO, SRC_KB, SRC_ZERO, ACC_BETA);
         24: u = mk(OP_MUL, SRC_T0, SRC_HH,     SRC_KA,   ACC_ALPHA);
         25: u = mk(OP_ADD, SRC_XA, SRC_PA,     SRC_T0,   ACC_ALPHA);
         26: u = mk(OP_MUL, SRC_T0, SRC_HH,     SRC_KB,   ACC_ALPHA);
         27: u = mk(OP_ADD, SRC_XB, SRC_PB,     SRC_T0,   ACC_ALPHA);
         // k2
         28: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XB,   ACC_ALPHA);
         29: u = mk(OP_SUB, SRC_T1, SRC_MA,     SRC_T0,   ACC_ALPHA);
         30: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XA,   ACC_ALPHA);
         31: u = mk(OP_SUB, SRC_KA, SRC_T1,     SRC_T0,   ACC_ALPHA);
         32: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XA,   ACC_ALPHA);
         33: u = mk(OP_ADD, SRC_T1, SRC_MB,     SRC_T0,   ACC_ALPHA);
         34: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XB,   ACC_ALPHA);
         35: u = mk(OP_SUB, SRC_KB, SRC_T1,     SRC_T0,   ACC_ALPHA);
         36: u = mk(OP_ACC_ADD2, SRC_ZERO, SRC_KA, SRC_ZERO, ACC_ALPHA);
         37: u = mk(OP_ACC_ADD2, SRC_ZERO, SRC_KB, SRC_ZERO, ACC_BETA);
         38: u = mk(OP_MUL, SRC_T0, SRC_HH,     SRC_KA,   ACC_ALPHA);
         39: u = mk(OP_ADD, SRC_XA, SRC_PA,     SRC_T0,   ACC_ALPHA);
         40: u = mk(OP_MUL, SRC_T0, SRC_HH,     SRC_KB,   ACC_ALPHA);
         41: u = mk(OP_ADD, SRC_XB, SRC_PB,     SRC_T0,   ACC_ALPHA);
         // k3
         42: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XB,   ACC_ALPHA);
         43: u = mk(OP_SUB, SRC_T1, SRC_MA,     SRC_T0,   ACC_ALPHA);
         44: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XA,   ACC_ALPHA);
         45: u = mk(OP_SUB, SRC_KA, SRC_T1,     SRC_T0,   ACC_ALPHA);
         46: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XA,   ACC_ALPHA);
         47: u = mk(OP_ADD, SRC_T1, SRC_MB,     SRC_T0,   ACC_ALPHA);
         48: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XB,   ACC_ALPHA);
         49: u = mk(OP_SUB, SRC_KB, SRC_T1,     SRC_T0,   ACC_ALPHA);
         50: u = mk(OP_ACC_ADD2, SRC_ZERO, SRC_KA, SRC_ZERO, ACC_ALPHA);
         51: u = mk(OP_ACC_ADD2, SRC_ZERO, SRC_KB, SRC_ZERO, ACC_BETA);
         52: u = mk(OP_MUL, SRC_T0, SRC_H,      SRC_KA,   ACC_ALPHA);
         53: u = mk(OP_ADD, SRC_XA, SRC_PA,     SRC_T0,   ACC_ALPHA);
         54: u = mk(OP_MUL, SRC_T0, SRC_H,      SRC_KB,   ACC_ALPHA);
         55: u = mk(OP_ADD, SRC_XB, SRC_PB,     SRC_T0,   ACC_ALPHA);
         // k4
         56: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XB,   ACC_ALPHA);
         57: u = mk(OP_SUB, SRC_T1, SRC_MA,     SRC_T0,   ACC_ALPHA);
         58: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XA,   ACC_ALPHA);
         59: u = mk(OP_SUB, SRC_KA, SRC_T1,     SRC_T0,   ACC_ALPHA);
         60: u = mk(OP_MUL, SRC_T0, SRC_W,      SRC_XA,   ACC_ALPHA);
         61: u = mk(OP_ADD, SRC_T1, SRC_MB,     SRC_T0,   ACC_ALPHA);
         62: u = mk(OP_MUL, SRC_T0, SRC_DECAY,  SRC_XB,   ACC_ALPHA);
         63: u = mk(OP_SUB, SRC_KB, SRC_T1,     SRC_T0,   ACC_ALPHA);
         64: u = mk(OP_ACC_ADD, SRC_ZERO, SRC_KA, SRC_ZERO, ACC_ALPHA);
         65: u = mk(OP_ACC_ADD, SRC_ZERO, SRC_KB, SRC_ZERO, ACC_BETA);
         // flux update, written straight into the state
         66: u = mk(OP_ACC_SAT, SRC_T1, SRC_ZERO, SRC_ZERO, ACC_ALPHA);
         67: u = mk(OP_MUL, SRC_T0, SRC_H6,     SRC_T1,   ACC_ALPHA);
         68: u = mk(OP_ADD, SRC_PA, SRC_PA,     SRC_T0,   ACC_ALPHA);
         69: u = mk(OP_ACC_SAT, SRC_T1, SRC_ZERO, SRC_ZERO, ACC_BETA);
         70: u = mk(OP_MUL, SRC_T0, SRC_H6,     SRC_T1,   ACC_ALPHA);
         71: u = mk(OP_ADD, SRC_PB, SRC_PB,     SRC_T0,   ACC_ALPHA);
         default: u = mk(OP_NOP, SRC_ZERO, SRC_ZERO, SRC_ZERO, ACC_ALPHA);
      endcase
      return u;
   endfunction

endpackage

// File: sv/rotor_flux_observer_rk4_core.sv
// Top level of the rotor flux observer: configuration registers, microcode
// sequencer, operand registers and the reciprocal multiply for h/6.
// Depends on rfo_pkg and rfo_alu.
//
// Usage:
//  - csr_ channel writes one of six registers (index 0..5: decay coefficient,
//    magnetizing gain, pole pair factor, step size, initial alpha and beta
//    flux); other indexes are dropped. csr_ready is high whenever reset is low.
//  - req_ channel takes one item: three phase currents, mechanical speed and
//    a restart flag that reloads the flux from the initial registers first.
//  - rsp_ channel returns the new alpha/beta flux pair, one item per request.
//  - All arithmetic runs through one shared saturating multiplier/adder,
//    one microcode step per cycle over 72 steps; a commit state then hands
//    the result over to the output register.
//  - A new item is taken only once the previous one has been committed;
//    req_ready is high only while the sequencer is idle.
//  - The result sits in an output register, so a new item may be accepted
//    while the previous result waits; a stalled receiver holds the next
//    result back in its final cycle, and the block stops there.
//  - Reset clears the flux state and the registers to their defaults; the
//    block is ready in the first cycle with reset low.
module rotor_flux_observer_rk4_core
   import rfo_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_phase_a_current,
   input  logic signed [DATA_W-1:0] req_phase_b_current,
   input  logic signed [DATA_W-1:0] req_phase_c_current,
   input  logic signed [DATA_W-1:0] req_mech_speed,
   input  logic                     req_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_flux_alpha,
   output logic signed [DATA_W-1:0] rsp_flux_beta
);

   localparam longint C0667_L  = ((longint'(6670) << FRAC_BITS) + 5000) / 10000;
   localparam longint C06667_L = ((longint'(6667) << FRAC_BITS) + 5000) / 10000;
   localparam longint C0866_L  = ((longint'(8660) << FRAC_BITS) + 5000) / 10000;
   localparam logic signed [DATA_W-1:0] C_0667  = DATA_W'(C0667_L);
   localparam logic signed [DATA_W-1:0] C_06667 = DATA_W'(C06667_L);
   localparam logic signed [DATA_W-1:0] C_0866  = DATA_W'(C0866_L);
   localparam logic signed [DATA_W-1:0] C_HALF  = DATA_W'(longint'(1) << (FRAC_BITS - 1));
   localparam logic signed [DATA_W-1:0] ONE_FX  = DATA_W'(longint'(1) << FRAC_BITS);
   localparam logic [UOP_STEP_W-1:0]    LAST_STEP = UOP_STEP_W'(UOP_COUNT - 1);
   // ceil(2^34 / 6): multiply and shift gives floor(h / 6) for any 32-bit h
   localparam logic [DATA_W-1:0]        RECIP_SIX    = 32'hAAAA_AAAB;
   localparam int                       RECIP_SIX_SH = 34;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_COMMIT
   } state_type;

   // configuration
   logic signed [DATA_W-1:0] decay_ff;
   logic signed [DATA_W-1:0] mag_ff;
   logic signed [DATA_W-1:0] pole_ff;
   logic [STEP_SIZE_W-1:0]   step_size_ff;
   logic signed [DATA_W-1:0] init_alpha_ff;
   logic signed [DATA_W-1:0] init_beta_ff;

   // sequencer
   state_type               state_ff;
   logic [UOP_STEP_W-1:0]   step_ff;
   uop_type                 uop_ff;
   logic                    rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_alpha_ff;
   logic signed [DATA_W-1:0] rsp_beta_ff;

   // operands and working registers
   logic signed [DATA_W-1:0] in_a_ff, in_b_ff, in_c_ff, in_ws_ff;
   logic signed [DATA_W-1:0] flux_a_ff, flux_b_ff;
   logic signed [DATA_W-1:0] ia_ff, ib_ff, w_ff, ma_ff, mb_ff;
   logic signed [DATA_W-1:0] xa_ff, xb_ff, ka_ff, kb_ff, t0_ff, t1_ff;

   // h/6
   logic [STEP_SIZE_W-1:0] h6_ff;

   logic                     req_accept;
   logic                     commit_go;
   logic                     alu_write;
   alu_ctl_type              alu_ctl;
   logic signed [DATA_W-1:0] opa;
   logic signed [DATA_W-1:0] opb;
   logic signed [DATA_W-1:0] alu_result;

   assign csr_ready      = !reset;
   assign req_ready      = (state_ff == ST_IDLE) && !reset;
   assign req_accept     = req_valid && req_ready;
   assign commit_go      = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_flux_alpha = rsp_alpha_ff;
   assign rsp_flux_beta  = rsp_beta_ff;

   always_comb begin
      alu_ctl.fire    = (state_ff == ST_RUN);
      alu_ctl.op      = uop_ff.op;
      alu_ctl.acc_sel = uop_ff.acc_sel;
   end
   assign alu_write       = alu_ctl.fire && (uop_ff.op == OP_MUL || uop_ff.op == OP_ADD ||
                                             uop_ff.op == OP_SUB || uop_ff.op == OP_ACC_SAT);

   function automatic logic signed [DATA_W-1:0] src_value(src_type s);
      logic signed [DATA_W-1:0] v;
      unique case (s)
         SRC_ZERO:   v = '0;
         SRC_CHALF:  v = C_HALF;
         SRC_C0667:  v = C_0667;
         SRC_C06667: v = C_06667;
         SRC_C0866:  v = C_0866;
         SRC_DECAY:  v = decay_ff;
         SRC_MAG:    v = mag_ff;
         SRC_POLE:   v = pole_ff;
         SRC_H:      v = DATA_W'(step_size_ff);
         SRC_HH:     v = DATA_W'(step_size_ff[STEP_SIZE_W-1:1]);
         SRC_H6:     v = DATA_W'(h6_ff);
         SRC_A:      v = in_a_ff;
         SRC_B:      v = in_b_ff;
         SRC_C:      v = in_c_ff;
         SRC_WS:     v = in_ws_ff;
         SRC_PA:     v = flux_a_ff;
         SRC_PB:     v = flux_b_ff;
         SRC_IA:     v = ia_ff;
         SRC_IB:     v = ib_ff;
         SRC_W:      v = w_ff;
         SRC_MA:     v = ma_ff;
         SRC_MB:     v = mb_ff;
         SRC_XA:     v = xa_ff;
         SRC_XB:     v = xb_ff;
         SRC_KA:     v = ka_ff;
         SRC_KB:     v = kb_ff;
         SRC_T0:     v = t0_ff;
         SRC_T1:     v = t1_ff;
         default:    v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      opa = src_value(uop_ff.srca);
      opb = src_value(uop_ff.srcb);
   end

   rfo_alu #(
      .FRAC_BITS(FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .ctl   (alu_ctl),
      .opa   (opa),
      .opb   (opb),
      .result(alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff      <= '0;
         mag_ff        <= '0;
         pole_ff       <= ONE_FX;
         step_size_ff  <= '0;
         init_alpha_ff <= '0;
         init_beta_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECAY:      decay_ff      <= csr_data;
            CSR_MAG:        mag_ff        <= csr_data;
            CSR_POLE:       pole_ff       <= csr_data;
            CSR_STEP:       step_size_ff  <= csr_data[STEP_SIZE_W-1:0];
            CSR_INIT_ALPHA: init_alpha_ff <= csr_data;
            CSR_INIT_BETA:  init_beta_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         uop_ff       <= uop_at('0);
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result, else drop the one the receiver took
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
            rsp_alpha_ff <= flux_a_ff;
            rsp_beta_ff  <= flux_b_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_RUN;
                  step_ff  <= '0;
                  uop_ff   <= uop_at('0);
               end
            end
            ST_RUN: begin
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_COMMIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
                  uop_ff  <= uop_at(step_ff + 1'b1);
               end
            end
            ST_COMMIT: begin
               // hold until the output register is free
               if (commit_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // flux state
   always_ff @(posedge clock) begin
      if (reset) begin
         flux_a_ff <= '0;
         flux_b_ff <= '0;
      end else if (req_accept && req_restart) begin
         flux_a_ff <= init_alpha_ff;
         flux_b_ff <= init_beta_ff;
      end else if (alu_write) begin
         if (uop_ff.dst == SRC_PA) flux_a_ff <= alu_result;
         if (uop_ff.dst == SRC_PB) flux_b_ff <= alu_result;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_a_ff  <= req_phase_a_current;
         in_b_ff  <= req_phase_b_current;
         in_c_ff  <= req_phase_c_current;
         in_ws_ff <= req_mech_speed;
      end
      if (alu_write) begin
         unique case (uop_ff.dst)
            SRC_IA:  ia_ff <= alu_result;
            SRC_IB:  ib_ff <= alu_result;
            SRC_W:   w_ff  <= alu_result;
            SRC_MA:  ma_ff <= alu_result;
            SRC_MB:  mb_ff <= alu_result;
            SRC_XA:  xa_ff <= alu_result;
            SRC_XB:  xb_ff <= alu_result;
            SRC_KA:  ka_ff <= alu_result;
            SRC_KB:  kb_ff <= alu_result;
            SRC_T0:  t0_ff <= alu_result;
            SRC_T1:  t1_ff <= alu_result;
            default: begin
            end
         endcase
      end
   end

   // latch h/6 with the item; the user must keep the step size unchanged while it runs (not enforced here)
   always_ff @(posedge clock) begin
      if (req_accept) begin
         h6_ff <= STEP_SIZE_W'((64'(step_size_ff) * 64'(RECIP_SIX)) >> RECIP_SIX_SH);
      end
   end

endmodule

// File: sv/rfo_alu.sv
// Shared arithmetic unit: saturating fixed-point multiply, add, subtract,
// and the two wide RK4 accumulators. Depends on rfo_pkg.
module rfo_alu
   import rfo_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  alu_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] opa,
   input  logic signed [DATA_W-1:0] opb,
   output logic signed [DATA_W-1:0] result
);

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   logic signed [63:0]      prod;
   logic signed [63:0]      prod_shift;
   logic signed [63:0]      sum;
   logic signed [63:0]      diff;
   logic signed [ACC_W-1:0] acc_alpha_ff;
   logic signed [ACC_W-1:0] acc_beta_ff;
   logic signed [ACC_W-1:0] acc_cur;
   logic signed [ACC_W-1:0] opa_wide;

   assign prod       = 64'(opa) * 64'(opb);
   // arithmetic shift truncates toward minus infinity
   assign prod_shift = prod >>> FRAC_BITS;
   assign sum        = 64'(opa) + 64'(opb);
   assign diff       = 64'(opa) - 64'(opb);
   assign acc_cur    = (ctl.acc_sel == ACC_BETA) ? acc_beta_ff : acc_alpha_ff;
   assign opa_wide   = ACC_W'(opa);

   always_comb begin
      unique case (ctl.op)
         OP_MUL:     result = sat32(prod_shift);
         OP_ADD:     result = sat32(sum);
         OP_SUB:     result = sat32(diff);
         OP_ACC_SAT: result = sat32(64'(acc_cur));
         default:    result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         unique case (ctl.op)
            OP_ACC_LD: begin
               if (ctl.acc_sel == ACC_BETA) acc_beta_ff <= opa_wide;
               else acc_alpha_ff <= opa_wide;
            end
            OP_ACC_ADD: begin
               if (ctl.acc_sel == ACC_BETA) acc_beta_ff <= acc_beta_ff + opa_wide;
               else acc_alpha_ff <= acc_alpha_ff + opa_wide;
            end
            OP_ACC_ADD2: begin
               if (ctl.acc_sel == ACC_BETA) acc_beta_ff <= acc_beta_ff + (opa_wide <<< 1);
               else acc_alpha_ff <= acc_alpha_ff + (opa_wide <<< 1);
            end
            default: begin
            end
         endcase
      end
   end

endmodule
